// File: src/deq_pkg.sv
// shared constants and types for the double-ended queue
// command and error codes, queue depth, cell control struct; no dependencies
`default_nettype none
package deq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int ERR_W    = 2;
  localparam int COUNT_W  = 5;
  localparam int OUT_W    = 3 * DATA_W + ERR_W + COUNT_W + 1;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;
  localparam int OUT_TW   = OUT_BYTES * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // one-hot at most: what the chain does in this cycle
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_op_t;

endpackage
`default_nettype wire

// File: src/deq_cell.sv
// one storage cell of the deque chain: a data word and an occupied bit
// shifts with its neighbours on front operations; depends on deq_pkg
`default_nettype none
module deq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire deq_pkg::cell_op_t          op,
  input  wire logic [deq_pkg::DATA_W-1:0] push_value,
  input  wire logic [deq_pkg::DATA_W-1:0] left_data,
  input  wire logic                       left_valid,
  input  wire logic [deq_pkg::DATA_W-1:0] right_data,
  input  wire logic                       right_valid,
  output logic      [deq_pkg::DATA_W-1:0] data_o,
  output logic                            valid_o,
  output logic                            is_rear_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    priority if (op.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (op.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (op.push_back && !valid_r && left_valid) begin
      // first free cell takes the beat
      data_nxt  = push_value;
      valid_nxt = 1'b1;
    end else if (op.pop_back && valid_r && !right_valid) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_o    = data_r;
  assign valid_o   = valid_r;
  assign is_rear_o = valid_r & ~right_valid;

endmodule
`default_nettype wire

// File: src/deq_ctrl.sv
// command decode, entry counter and result register of the deque
// drives the cell chain operation; depends on deq_pkg
`default_nettype none
module deq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [deq_pkg::CMD_W-1:0]   cmd,
  input  wire logic                        empty_i,
  input  wire logic                        full_i,
  input  wire logic [deq_pkg::DATA_W-1:0]  front_data,
  input  wire logic [deq_pkg::DATA_W-1:0]  rear_data,
  output deq_pkg::cell_op_t                op,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [deq_pkg::DATA_W-1:0]  popped_o,
  output logic      [deq_pkg::ERR_W-1:0]   error_o,
  output logic      [deq_pkg::CNT_W-1:0]   count_o
);
  import deq_pkg::*;

  logic              accept;
  logic              is_push_f, is_push_b, is_pop_f, is_pop_b;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  logic [ERR_W-1:0]  error_r, error_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // a new beat enters only once the previous result has left
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    is_push_f = 1'b0;
    is_push_b = 1'b0;
    is_pop_f  = 1'b0;
    is_pop_b  = 1'b0;
    unique case (cmd)
      CMD_PUSH_FRONT: is_push_f = 1'b1;
      CMD_PUSH_BACK:  is_push_b = 1'b1;
      CMD_POP_FRONT:  is_pop_f  = 1'b1;
      CMD_POP_BACK:   is_pop_b  = 1'b1;
      default:        ; // status only
    endcase
  end

  always_comb begin
    op.push_front = accept & is_push_f & ~full_i;
    op.push_back  = accept & is_push_b & ~full_i;
    op.pop_front  = accept & is_pop_f  & ~empty_i;
    op.pop_back   = accept & is_pop_b  & ~empty_i;
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = popped_r;
    error_nxt  = error_r;
    if (accept) begin
      popped_nxt = '0;
      error_nxt  = ERR_OK;
      if ((is_push_f || is_push_b) && full_i) begin
        error_nxt = ERR_FULL;
      end else if ((is_pop_f || is_pop_b) && empty_i) begin
        error_nxt = ERR_EMPTY;
      end
      if (op.push_front || op.push_back) begin
        count_nxt = count_r + 1'b1;
      end else if (op.pop_front) begin
        count_nxt  = count_r - 1'b1;
        popped_nxt = front_data;
      end else if (op.pop_back) begin
        count_nxt  = count_r - 1'b1;
        popped_nxt = rear_data;
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    error_r  <= error_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign popped_o   = popped_r;
  assign error_o    = error_r;
  assign count_o    = count_r;

`ifndef NO_ASSERTIONS
  a_empty_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_i == (count_r == '0))
    else $error("chain occupancy and counter disagree on empty");

  a_full_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    full_i == (count_r == CNT_W'(DEPTH)))
    else $error("chain occupancy and counter disagree on full");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (op.push_front || op.push_back) |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not raise the count");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(count_r) && $stable(error_r))
    else $error("state moved while the result was stalled");
`endif

endmodule
`default_nettype wire

// File: src/double_ended_queue.sv
// deque top level: a chain of DEPTH cells packed from the front, plus control
// the result beat is registered and presented the cycle after its command beat
// throughput: one command per cycle while out_tready stays high
// front operations shift the whole chain; rear is the last occupied cell
// reset (rst_n low, synchronous): occupied bits, counter, result valid clear
// stored data words are not reset; depends on deq_pkg, deq_cell, deq_ctrl
`default_nettype none
module double_ended_queue (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,  // value[31:0]
  input  wire logic [2:0]                   in_tuser,  // cmd[2:0]
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // popped_value[31:0], error[33:32], count[38:34], is_empty[39],
  // front_value[71:40], rear_value[103:72]
  output logic      [deq_pkg::OUT_TW-1:0]   out_tdata
);
  import deq_pkg::*;

  cell_op_t          op;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_rear;
  logic [DATA_W-1:0] front_data, rear_data;
  logic [DATA_W-1:0] popped;
  logic [ERR_W-1:0]  error;
  logic [CNT_W-1:0]  count;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic              empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] l_data, r_data;
    logic              l_valid, r_valid;
    if (i == 0) begin : g_first
      assign l_data  = in_tdata;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .push_value (in_tdata),
      .left_data  (l_data),
      .left_valid (l_valid),
      .right_data (r_data),
      .right_valid(r_valid),
      .data_o     (cell_data[i]),
      .valid_o    (cell_valid[i]),
      .is_rear_o  (cell_rear[i])
    );
  end

  assign empty      = ~cell_valid[0];
  assign front_data = cell_valid[0] ? cell_data[0] : '0;

  // at most one cell flags itself as rear, so an or of gated words selects it
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | (cell_data[i] & {DATA_W{cell_rear[i]}});
    end
  end

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (in_tuser),
    .empty_i   (empty),
    .full_i    (cell_valid[DEPTH-1]),
    .front_data(front_data),
    .rear_data (rear_data),
    .op        (op),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .popped_o  (popped),
    .error_o   (error),
    .count_o   (count)
  );

  assign count_ext = {{COUNT_W{1'b0}}, count};

  assign out_tdata = {{(OUT_TW - OUT_W){1'b0}}, rear_data, front_data, empty,
                      count_ext[COUNT_W-1:0], error, popped};

endmodule
`default_nettype wire

// File: verif/deq_checker.sv
`timescale 1ns / 1ps
// scoreboard for the double-ended queue: watches both stream channels,
// keeps its own ring model and compares every result beat; depends on deq_pkg
module deq_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [31:0]                in_tdata,   // value[31:0]
  input  wire logic [2:0]                 in_tuser,   // cmd[2:0]
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  // popped_value[31:0], error[33:32], count[38:34], is_empty[39],
  // front_value[71:40], rear_value[103:72]
  input  wire logic [deq_pkg::OUT_TW-1:0] out_tdata,
  output int                              mismatches,
  output int                              outstanding
);
  import deq_pkg::*;

  // declared msb first so a cast of out_tdata lines up with the port layout
  typedef struct packed {
    logic [DATA_W-1:0]  rear;
    logic [DATA_W-1:0]  front;
    logic               empty;
    logic [COUNT_W-1:0] count;
    logic [ERR_W-1:0]   err;
    logic [DATA_W-1:0]  popped;
  } deq_result_t;

  logic [DATA_W-1:0] ring [DEPTH];
  int                head_idx;
  int                tail_idx;
  int                fill;
  deq_result_t       pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    head_idx    = 0;
    tail_idx    = 0;
    fill        = 0;
  end

  function automatic int ring_succ(int i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int ring_pred(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // applies one command to the model and returns what the block should report
  function automatic deq_result_t next_deque_result(logic [2:0] cmd, logic [31:0] val);
    deq_result_t res;
    res     = '0;
    res.err = ERR_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          res.err = ERR_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          head_idx       = ring_pred(head_idx);
          ring[head_idx] = val;
          fill++;
        end else begin
          ring[tail_idx] = val;
          tail_idx       = ring_succ(tail_idx);
          fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          res.err = ERR_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          res.popped = ring[head_idx];
          head_idx   = ring_succ(head_idx);
          fill--;
        end else begin
          tail_idx   = ring_pred(tail_idx);
          res.popped = ring[tail_idx];
          fill--;
        end
      end
      default: ; // status and the unused codes change nothing
    endcase
    res.count = COUNT_W'(fill);
    res.empty = (fill == 0);
    if (fill != 0) begin
      res.front = ring[head_idx];
      res.rear  = ring[ring_pred(tail_idx)];
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        pending_results.push_back(next_deque_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          got  = deq_result_t'(out_tdata[OUT_W-1:0]);
          check_field("popped_value", want.popped, got.popped);
          check_field("error", 32'(want.err), 32'(got.err));
          check_field("count", 32'(want.count), 32'(got.count));
          check_field("is_empty", 32'(want.empty), 32'(got.empty));
          check_field("front_value", want.front, got.front);
          check_field("rear_value", want.rear, got.rear);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// top of the double-ended queue testbench: clock, reset, command stimulus,
// result sink and verdict; depends on deq_pkg, double_ended_queue, deq_checker
module tb_top;
  import deq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_START   = 500;
  localparam int HOLD_CYCLES  = 300;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} cmd_mix_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata   = '0;   // value[31:0]
  logic [2:0]        in_tuser   = '0;   // cmd[2:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // popped_value[31:0], error[33:32], count[38:34], is_empty[39],
  // front_value[71:40], rear_value[103:72]
  logic [OUT_TW-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int cmds_sent    = 0;
  int stall_cycles = 0;

  double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  deq_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no handshake on either side for too long means the block has hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("double_ended_queue test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result sink: random back-pressure, a calm window, then one long hold-off
  initial begin
    int sink_cyc;
    sink_cyc = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      sink_cyc++;
      if (sink_cyc == HOLD_START) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_cyc >= 100 && sink_cyc < 400) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // one command beat; called at a rising edge, returns at the edge that takes it
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] val);
    bit calm;
    calm = (cmds_sent >= 600 && cmds_sent < 780);
    if (!calm && $urandom_range(99) < 8) begin
      // a single idle cycle
      in_tvalid <= 1'b0;
      in_tuser  <= 3'($urandom);
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    cmds_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_cmd(cmd_mix_t mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (r < 85) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < 95) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        return CMD_STATUS;
      end
      MIX_DRAIN: begin
        if (r < 85) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (r < 95) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return CMD_STATUS;
      end
      MIX_BALANCED: return 3'($urandom_range(CMD_STATUS));
      default:      return 3'($urandom);
    endcase
  endfunction

  initial begin
    int       n;
    int       run_len;
    int       r;
    cmd_mix_t mix;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: status, both pops, the unused codes
    send_cmd(CMD_STATUS, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'hffff_ffff);
    send_cmd(CMD_POP_BACK, 32'h8000_0000);
    send_cmd(CMD_UNUSED_5, 32'hffff_ffff);
    send_cmd(CMD_UNUSED_6, 32'h7fff_ffff);
    send_cmd(CMD_UNUSED_7, 32'h8000_0000);
    // value extremes at both ends, then unwind them
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    send_cmd(CMD_STATUS, 32'h1234_5678);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_PUSH_BACK, 32'h5a5a_a5a5);
    send_cmd(CMD_POP_FRONT, 32'h0);

    // runs of push-heavy and pop-heavy traffic reach full and empty repeatedly
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 35)      mix = MIX_FILL;
      else if (r < 70) mix = MIX_DRAIN;
      else if (r < 90) mix = MIX_BALANCED;
      else             mix = MIX_NOISE;
      run_len = $urandom_range(20, 50);
      for (int k = 0; k < run_len && n < RANDOM_ITEMS; k++) begin
        send_cmd(pick_cmd(mix), pick_value());
        n++;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/deq_pkg.sv
src/deq_cell.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
verif/deq_checker.sv
verif/tb_top.sv
